[hw/rtl/mwu_pkg.sv]
package mwu_pkg;

    // Register map, word index (byte address = 4 * index)
    localparam logic [2:0] REG_LEARNING_RATE = 3'd0;
    localparam logic [2:0] REG_MOMENTUM      = 3'd1;
    localparam logic [2:0] REG_SMOOTHING     = 3'd2;
    localparam logic [2:0] REG_OFFLINE       = 3'd3;
    localparam logic [2:0] REG_ITER_COUNT    = 3'd4;

    localparam logic [19:0] LR_RESET   = 20'd655;
    localparam logic [16:0] Q_ONE      = 17'd65536;
    localparam logic [15:0] ITER_RESET = 16'd1;

    // Dividend width of the rounded scaled gradient, one quotient bit per stage
    localparam int DIV_BITS = 36;

    // Side data that rides along the divider stages
    typedef struct packed {
        logic [9:0]         idx;
        logic signed [31:0] w;
        logic               neg;
    } t_div_meta;

    // round(v / 2^16), nearest, ties away from zero
    function automatic logic signed [39:0] rnd16(input logic signed [55:0] v);
        logic [55:0] mag;
        logic [55:0] q;
        mag = v[55] ? 56'(-v) : 56'(v);
        q   = (mag + 56'd32768) >> 16;
        return v[55] ? -$signed(40'(q)) : $signed(40'(q));
    endfunction

endpackage

[hw/rtl/mwu_divider.sv]
// Restoring divider, one quotient bit per pipeline stage
module mwu_divider (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [mwu_pkg::DIV_BITS-1:0]        i_dividend,
    input  logic [15:0]                         i_divisor,
    input  mwu_pkg::t_div_meta                  i_meta,
    output logic                                o_valid,
    output logic [mwu_pkg::DIV_BITS-1:0]        o_quot,
    output mwu_pkg::t_div_meta                  o_meta
);
    localparam int N = mwu_pkg::DIV_BITS;

    logic                c_v    [N+1];
    logic [15:0]         c_rem  [N+1];
    logic [N-1:0]        c_dq   [N+1];
    mwu_pkg::t_div_meta  c_meta [N+1];

    assign c_v[0]    = i_valid;
    assign c_rem[0]  = '0;
    assign c_dq[0]   = i_dividend;
    assign c_meta[0] = i_meta;

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [16:0]        trial;
        logic               ge;
        logic               r_v;
        logic [15:0]        r_rem;
        logic [N-1:0]       r_dq;
        mwu_pkg::t_div_meta r_meta;

        // shift in next dividend bit, subtract when it fits
        assign trial = {c_rem[k], c_dq[k][N-1]};
        assign ge    = trial >= {1'b0, i_divisor};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= c_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= ge ? 16'(trial - {1'b0, i_divisor}) : trial[15:0];
                r_dq   <= {c_dq[k][N-2:0], ge};
                r_meta <= c_meta[k];
            end
        end

        assign c_v[k+1]    = r_v;
        assign c_rem[k+1]  = r_rem;
        assign c_dq[k+1]   = r_dq;
        assign c_meta[k+1] = r_meta;
    end

    assign o_valid = c_v[N];
    assign o_quot  = c_dq[N];
    assign o_meta  = c_meta[N];

endmodule

[hw/rtl/mwu_delta_ram.sv]
// Previous-update store: one write port, one registered read port
module mwu_delta_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  logic signed [31:0]  i_wdata,
    input  logic                i_re,
    input  logic [AW-1:0]       i_raddr,
    output logic signed [31:0]  o_rdata
);
    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/momentum_weight_update_unit.sv]
// An accepted input word passes through 43 register stages (3 front, 36 divider,
// 3 update, 1 output); one word per cycle sustained while m_axis_tready and the clear pass allow.
// The rate is set by the delta-store loop: read, momentum multiply, add and
// saturate, write back, all within one stage, with forwarding for repeated indexes.
// Reset (synchronous, active low) restores the registers and then zeroes the delta
// store, one entry per cycle, while s_axis_tready stays low.
module momentum_weight_update_unit #(
    parameter int NUM_WEIGHTS = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // APB configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input words
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [79:0]  s_axis_tdata,  // element_index[9:0], weight_in[41:10], gradient[73:42]
    // output words
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata   // weight_out[31:0], step_applied[63:32], saturated[64]
);
    localparam int AW = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
    localparam logic [16:0] NW = 17'(NUM_WEIGHTS);
    localparam int N = mwu_pkg::DIV_BITS;

    // ---------------- configuration ----------------
    logic [19:0] r_lr;
    logic [16:0] r_mom;
    logic        r_smooth;
    logic        r_offline;
    logic [15:0] r_iter;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr      <= mwu_pkg::LR_RESET;
            r_mom     <= '0;
            r_smooth  <= 1'b0;
            r_offline <= 1'b0;
            r_iter    <= mwu_pkg::ITER_RESET;
        end else if (cfg_we) begin
            case (paddr[4:2])
                mwu_pkg::REG_LEARNING_RATE: r_lr      <= pwdata[19:0];
                mwu_pkg::REG_MOMENTUM:      r_mom     <= pwdata[16:0];
                mwu_pkg::REG_SMOOTHING:     r_smooth  <= pwdata[0];
                mwu_pkg::REG_OFFLINE:       r_offline <= pwdata[0];
                mwu_pkg::REG_ITER_COUNT:    r_iter    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            mwu_pkg::REG_LEARNING_RATE: prdata = {12'd0, r_lr};
            mwu_pkg::REG_MOMENTUM:      prdata = {15'd0, r_mom};
            mwu_pkg::REG_SMOOTHING:     prdata = {31'd0, r_smooth};
            mwu_pkg::REG_OFFLINE:       prdata = {31'd0, r_offline};
            mwu_pkg::REG_ITER_COUNT:    prdata = {16'd0, r_iter};
            default:                    prdata = '0;
        endcase
    end

    // effective momentum and divisor
    logic [16:0] mom_eff;
    logic [17:0] one_minus_m;
    logic [15:0] divisor;

    assign mom_eff     = (r_mom > mwu_pkg::Q_ONE) ? mwu_pkg::Q_ONE : r_mom;
    assign one_minus_m = 18'(mwu_pkg::Q_ONE) - 18'(mom_eff);
    assign divisor     = (r_offline && r_iter != 16'd0) ? r_iter : 16'd1;

    // ---------------- stall and delta-store clear ----------------
    logic          en;
    logic          r_out_valid;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en && !r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(NUM_WEIGHTS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ---------------- P0: input register ----------------
    logic               r_p0_valid;
    logic [9:0]         r_p0_idx;
    logic signed [31:0] r_p0_w;
    logic signed [31:0] r_p0_g;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_valid <= 1'b0;
        end else if (en) begin
            r_p0_valid <= s_axis_tvalid && !r_clr_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p0_idx <= s_axis_tdata[9:0];
            r_p0_w   <= s_axis_tdata[41:10];
            r_p0_g   <= s_axis_tdata[73:42];
        end
    end

    // ---------------- P1: gradient times learning rate ----------------
    logic               r_p1_valid;
    logic [9:0]         r_p1_idx;
    logic signed [31:0] r_p1_w;
    logic signed [52:0] r_p1_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (en) begin
            r_p1_valid <= r_p0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_idx  <= r_p0_idx;
            r_p1_w    <= r_p0_w;
            r_p1_prod <= 53'(r_p0_g * $signed({1'b0, r_lr}));
        end
    end

    // ---------------- P2: magnitude plus half divisor, drop 16 bits ----------------
    logic [51:0]          p1_mag;
    logic [51:0]          p1_sum;
    logic                 r_p2_valid;
    logic [N-1:0]         r_p2_b;
    mwu_pkg::t_div_meta   r_p2_meta;

    assign p1_mag = r_p1_prod[52] ? 52'(-r_p1_prod) : 52'(r_p1_prod);
    assign p1_sum = p1_mag + 52'({divisor, 15'd0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else if (en) begin
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p2_b         <= p1_sum[51:16];
            r_p2_meta.idx  <= r_p1_idx;
            r_p2_meta.w    <= r_p1_w;
            r_p2_meta.neg  <= r_p1_prod[52];
        end
    end

    // ---------------- divider (T0 at its output) ----------------
    logic               t0_valid;
    logic [N-1:0]       t0_quot;
    mwu_pkg::t_div_meta t0_meta;

    mwu_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_p2_valid),
        .i_dividend (r_p2_b),
        .i_divisor  (divisor),
        .i_meta     (r_p2_meta),
        .o_valid    (t0_valid),
        .o_quot     (t0_quot),
        .o_meta     (t0_meta)
    );

    logic signed [36:0] t0_scaled;
    logic [AW+9:0]      t0_idx_ext;

    assign t0_scaled  = t0_meta.neg ? -$signed({1'b0, t0_quot}) : $signed({1'b0, t0_quot});
    assign t0_idx_ext = (AW+10)'(t0_meta.idx);

    // ---------------- T1: delta read data, smoothing product ----------------
    logic               r_t1_valid;
    logic [9:0]         r_t1_idx;
    logic signed [31:0] r_t1_w;
    logic signed [36:0] r_t1_scaled;
    logic signed [54:0] r_t1_prod;
    logic               r_t1_fwd;
    logic signed [31:0] r_t1_fwd_val;
    logic signed [31:0] ram_rdata;

    // T2 signals used for forwarding
    logic               r_t2_valid;
    logic [9:0]         r_t2_idx;
    logic               t2_in_range;
    logic signed [31:0] t2_step;
    logic               t2_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_valid <= 1'b0;
            r_t1_fwd   <= 1'b0;
        end else if (en) begin
            r_t1_valid <= t0_valid;
            // word leaving T2 writes the same entry on this edge: read returns old data
            r_t1_fwd   <= t0_valid && r_t2_valid && t2_in_range && (r_t2_idx == t0_meta.idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1_idx     <= t0_meta.idx;
            r_t1_w       <= t0_meta.w;
            r_t1_scaled  <= t0_scaled;
            r_t1_prod    <= 55'(t0_scaled * $signed(one_minus_m));
            r_t1_fwd_val <= t2_step;
        end
    end

    // pick previous update: zero out of range, else word just ahead, word written at read time, or store
    logic               t1_in_range;
    logic signed [31:0] t1_last;
    logic signed [39:0] t1_fresh;

    assign t1_in_range = 17'(r_t1_idx) < NW;

    always_comb begin
        if (!t1_in_range) begin
            t1_last = '0;
        end else if (r_t2_valid && t2_in_range && r_t2_idx == r_t1_idx) begin
            t1_last = t2_step;
        end else if (r_t1_fwd) begin
            t1_last = r_t1_fwd_val;
        end else begin
            t1_last = ram_rdata;
        end
    end

    assign t1_fresh = r_smooth ? mwu_pkg::rnd16(56'(r_t1_prod)) : 40'(r_t1_scaled);

    // ---------------- T2: momentum term, step, write back ----------------
    logic signed [31:0] r_t2_w;
    logic signed [31:0] r_t2_last;
    logic signed [39:0] r_t2_fresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t2_valid <= 1'b0;
        end else if (en) begin
            r_t2_valid <= r_t1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t2_idx   <= r_t1_idx;
            r_t2_w     <= r_t1_w;
            r_t2_last  <= t1_last;
            r_t2_fresh <= t1_fresh;
        end
    end

    logic signed [49:0] t2_mprod;
    logic signed [39:0] t2_mterm;
    logic signed [40:0] t2_sum;

    assign t2_in_range = 17'(r_t2_idx) < NW;
    assign t2_mprod    = 50'(r_t2_last * $signed({1'b0, mom_eff}));
    assign t2_mterm    = mwu_pkg::rnd16(56'(t2_mprod));
    assign t2_sum      = 41'(t2_mterm) + 41'(r_t2_fresh);

    always_comb begin
        if (t2_sum > 41'sd2147483647) begin
            t2_step = 32'sh7fffffff;
            t2_clip = 1'b1;
        end else if (t2_sum < -41'sd2147483648) begin
            t2_step = 32'sh80000000;
            t2_clip = 1'b1;
        end else begin
            t2_step = t2_sum[31:0];
            t2_clip = 1'b0;
        end
    end

    // store port: clearing pass or write back
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic signed [31:0] ram_wdata;
    logic [AW+9:0] t2_idx_ext;

    assign t2_idx_ext = (AW+10)'(r_t2_idx);
    assign ram_we     = r_clr_busy || (en && r_t2_valid && t2_in_range);
    assign ram_waddr  = r_clr_busy ? r_clr_addr : t2_idx_ext[AW-1:0];
    assign ram_wdata  = r_clr_busy ? 32'sd0 : t2_step;

    mwu_delta_ram #(
        .DEPTH (NUM_WEIGHTS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (en),
        .i_raddr (t0_idx_ext[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // ---------------- T3: weight update ----------------
    logic               r_t3_valid;
    logic signed [31:0] r_t3_w;
    logic signed [31:0] r_t3_step;
    logic               r_t3_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t3_valid <= 1'b0;
        end else if (en) begin
            r_t3_valid <= r_t2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t3_w    <= r_t2_w;
            r_t3_step <= t2_step;
            r_t3_clip <= t2_clip;
        end
    end

    logic signed [32:0] t3_sum;
    logic signed [31:0] t3_nw;
    logic               t3_clip;

    assign t3_sum = 33'(r_t3_w) + 33'(r_t3_step);

    always_comb begin
        if (t3_sum > 33'sd2147483647) begin
            t3_nw   = 32'sh7fffffff;
            t3_clip = 1'b1;
        end else if (t3_sum < -33'sd2147483648) begin
            t3_nw   = 32'sh80000000;
            t3_clip = 1'b1;
        end else begin
            t3_nw   = t3_sum[31:0];
            t3_clip = r_t3_clip;
        end
    end

    // ---------------- output register ----------------
    logic signed [31:0] r_out_w;
    logic signed [31:0] r_out_step;
    logic               r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_t3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_w    <= t3_nw;
            r_out_step <= r_t3_step;
            r_out_sat  <= t3_clip;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_sat, r_out_step, r_out_w};

    // ---------------- assertions ----------------
    a_no_accept_in_clear: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) r_clr_busy |-> !s_axis_tready)
        else $error("input accepted during store clear");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> r_clr_busy)
        else $error("clear pass not started by reset");

    a_fwd_with_word: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) r_t1_fwd |-> r_t1_valid)
        else $error("forward flag without a word in T1");

    a_stall_holds_step: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) (r_t2_valid && !en) |=> $stable(r_t2_last) && r_t2_valid)
        else $error("T2 word changed during stall");

endmodule

[test/mwu_checker.sv]
`timescale 1ns / 100ps

// Watches both streams, predicts each output word and compares in order.
module mwu_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [79:0]  s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [71:0]  m_axis_tdata,
    output int           o_errors,
    output int           o_pending,
    output int           o_matched,
    output int           o_clipped
);
    localparam int NW = 1024;

    logic [19:0]        lr_q;
    logic [16:0]        mom_q;
    logic               smooth_q;
    logic               offline_q;
    logic [15:0]        iter_q;
    logic signed [31:0] delta_mem [NW];
    logic [71:0]        expected_words [$];

    // round(v / d), nearest, ties away from zero
    function automatic longint div_near(input longint v, input longint d);
        longint mag;
        longint q;
        mag = (v < 0) ? -v : v;
        q = (mag + (d >>> 1)) / d;
        return (v < 0) ? -q : q;
    endfunction

    function automatic longint clip32(input longint v, inout bit clip);
        if (v > 64'sd2147483647) begin
            clip = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            clip = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Compute the output word for one input word and update the delta store
    function automatic logic [71:0] update_weight(input logic [79:0] word);
        logic [9:0] idx;
        longint w, g, last, m, cnt, scaled, mterm, fresh, step, nw;
        bit clip;
        idx  = word[9:0];
        w    = longint'($signed(word[41:10]));
        g    = longint'($signed(word[73:42]));
        clip = 0;
        last = (idx < NW) ? longint'(delta_mem[idx]) : 0;
        m    = (mom_q > mwu_pkg::Q_ONE) ? 65536 : longint'(mom_q);
        cnt  = 1;
        if (offline_q) cnt = (iter_q != 0) ? longint'(iter_q) : 1;
        scaled = div_near(g * longint'(lr_q), cnt * 65536);
        mterm  = div_near(last * m, 65536);
        fresh  = smooth_q ? div_near(scaled * (65536 - m), 65536) : scaled;
        step   = clip32(mterm + fresh, clip);
        nw     = clip32(w + step, clip);
        if (idx < NW) delta_mem[idx] = 32'(step);
        return {7'd0, clip, step[31:0], nw[31:0]};
    endfunction

    assign o_pending = expected_words.size();

    always @(posedge i_clk) begin
        logic [71:0] exp_w;
        if (!i_rst_n) begin
            lr_q      <= mwu_pkg::LR_RESET;
            mom_q     <= '0;
            smooth_q  <= 1'b0;
            offline_q <= 1'b0;
            iter_q    <= mwu_pkg::ITER_RESET;
            for (int i = 0; i < NW; i++) delta_mem[i] = '0;
            expected_words.delete();
            o_errors  <= 0;
            o_matched <= 0;
            o_clipped <= 0;
        end else begin
            // register writes
            if (psel && penable && pwrite) begin
                case (paddr[4:2])
                    mwu_pkg::REG_LEARNING_RATE: lr_q      <= pwdata[19:0];
                    mwu_pkg::REG_MOMENTUM:      mom_q     <= pwdata[16:0];
                    mwu_pkg::REG_SMOOTHING:     smooth_q  <= pwdata[0];
                    mwu_pkg::REG_OFFLINE:       offline_q <= pwdata[0];
                    mwu_pkg::REG_ITER_COUNT:    iter_q    <= pwdata[15:0];
                    default: ;
                endcase
            end
            // accepted input word
            if (s_axis_tvalid && s_axis_tready)
                expected_words.push_back(update_weight(s_axis_tdata));
            // accepted output word
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected output word %h", $time, m_axis_tdata);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (exp_w[64:0] != m_axis_tdata[64:0]) begin
                        $display("%0t: mismatch expected w=%h step=%h sat=%b", $time,
                                 exp_w[31:0], exp_w[63:32], exp_w[64]);
                        $display("%0t:          actual   w=%h step=%h sat=%b", $time,
                                 m_axis_tdata[31:0], m_axis_tdata[63:32],
                                 m_axis_tdata[64]);
                        o_errors <= o_errors + 1;
                    end else begin
                        o_matched <= o_matched + 1;
                        if (exp_w[64]) o_clipped <= o_clipped + 1;
                    end
                end
            end
        end
    end

endmodule

[test/momentum_weight_update_unit_tb.sv]
`timescale 1ns / 100ps

module momentum_weight_update_unit_tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    int          errors;
    int          pending;
    int          matched;
    int          clipped;
    int          sent;

    momentum_weight_update_unit u_dut (.*);

    mwu_checker u_check (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .o_errors(errors), .o_pending(pending), .o_matched(matched),
        .o_clipped(clipped)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    // Receiver: random stalls, with stretches of none
    initial begin
        int n;
        m_axis_tready = 1'b0;
        forever begin
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            repeat (n) @(posedge i_clk);
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            m_axis_tready <= 1'b0;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [19:0] lr, input logic [16:0] mom,
                              input logic smooth, input logic offl,
                              input logic [15:0] iter);
        write_reg(mwu_pkg::REG_LEARNING_RATE, 32'(lr));
        write_reg(mwu_pkg::REG_MOMENTUM, 32'(mom));
        write_reg(mwu_pkg::REG_SMOOTHING, 32'(smooth));
        write_reg(mwu_pkg::REG_OFFLINE, 32'(offl));
        write_reg(mwu_pkg::REG_ITER_COUNT, 32'(iter));
    endtask

    // Wait for every expected word, then drain the pipeline
    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // One input word; keeps tvalid high if the next word follows at once
    task automatic send_word(input logic [9:0] idx, input logic [31:0] w,
                             input logic [31:0] g, input bit random_gap);
        int n;
        n = random_gap ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15)) : 0;
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, g, w, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
    endtask

    task automatic idle_input();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random word: small gradients in half the cases, extremes in a quarter
    task automatic send_random();
        logic [31:0] w, g;
        logic [9:0]  idx;
        idx = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 7)) : 10'($urandom);
        case ($urandom_range(0, 3))
            0: g = $urandom;
            1: g = {{12{1'b0}}, 20'($urandom)} ^ {32{$urandom_range(0, 1) == 1}};
            2: g = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: g = 32'($signed(16'($urandom)));
        endcase
        w = ($urandom_range(0, 4) == 0) ? {$urandom_range(0, 1) == 1, {31{1'b1}}}
                                         : $urandom;
        send_word(idx, w, g, 1'b1);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        sent          = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, extremes, repeated index, last index
        send_word(10'd0, 32'h00010000, 32'h00010000, 1'b0);
        send_word(10'd0, 32'h7fffffff, 32'h7fffffff, 1'b0);
        send_word(10'd1023, 32'h80000000, 32'h80000000, 1'b0);
        idle_input();
        drain();
        set_config(20'hfffff, 17'd65536, 1'b0, 1'b0, 16'd1);
        send_word(10'd5, 32'h7fffffff, 32'h7fffffff, 1'b0);
        send_word(10'd5, 32'h80000000, 32'h80000000, 1'b0);
        send_word(10'd5, 32'h00000000, 32'h00000001, 1'b0);
        send_word(10'd1023, 32'hffffffff, 32'hffff0000, 1'b0);
        idle_input();
        drain();
        // momentum above one is clamped, smoothing on
        set_config(20'd65536, 17'h1ffff, 1'b1, 1'b0, 16'd1);
        send_word(10'd5, 32'h00001234, 32'h00018000, 1'b0);
        send_word(10'd7, 32'h00000000, 32'hffff8000, 1'b0);
        idle_input();
        drain();
        // offline, zero iteration count acts as one, then the largest count
        set_config(20'd65536, 17'd32768, 1'b1, 1'b1, 16'd0);
        send_word(10'd9, 32'h00000000, 32'h00030001, 1'b0);
        send_word(10'd9, 32'h00000000, 32'hfffcffff, 1'b0);
        idle_input();
        drain();
        write_reg(mwu_pkg::REG_ITER_COUNT, 32'hffff);
        send_word(10'd9, 32'h40000000, 32'h7fffffff, 1'b0);
        send_word(10'd10, 32'h00000000, 32'h00000000, 1'b0);
        idle_input();
        drain();

        // Random phases with changing settings
        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 0)
                set_config(20'd0, 17'd0, 1'b0, 1'b0, 16'd1);
            else
                set_config(($urandom_range(0, 3) == 0) ? 20'hfffff : 20'($urandom),
                           ($urandom_range(0, 3) == 0) ? 17'd65536
                                                       : 17'($urandom_range(0, 70000)),
                           1'($urandom), 1'($urandom),
                           16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 3)
                                                         : $urandom));
            for (int k = 0; k < 95; k++) send_random();
            idle_input();
            drain();
        end

        $display("Sent %0d words over 17 register settings; %0d results matched, %0d clipped.",
                 sent, matched, clipped);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
